[design/wsd_pkg.sv]
// shared types and codes for the work-stealing task deques
package wsd_pkg;

  localparam int unsigned TASK_W = 16;
  localparam int unsigned WID_W  = 3;
  localparam int unsigned CFG_W  = 4;
  localparam int unsigned STAT_W = 2;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FETCH = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_SKIP = 2'd2;
  localparam logic [STAT_W-1:0] ST_NONE = 2'd3;

  // pointer update requests for the selected worker
  typedef struct packed {
    logic push;
    logic pop;
    logic steal;
  } ptr_op_t;

  // occupancy of the selected worker's deque
  typedef struct packed {
    logic empty;
    logic full;
  } ptr_stat_t;

endpackage

[design/wsd_task_mem.sv]
// task handle storage, one port, registered read data
module wsd_task_mem #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic                       re,
  input  logic [AW-1:0]              addr,
  input  logic [wsd_pkg::TASK_W-1:0] wdata,
  output logic [wsd_pkg::TASK_W-1:0] rdata
);
  import wsd_pkg::*;

  logic [TASK_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

[design/wsd_ptr_file.sv]
// top and bottom pointers per worker, occupancy check and slot math for one worker
module wsd_ptr_file #(
  parameter int unsigned WORKERS     = 8,
  parameter int unsigned QUEUE_DEPTH = 1024,
  parameter int unsigned WW          = 3,
  parameter int unsigned QW          = 10
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [WW-1:0]      sel,
  input  wsd_pkg::ptr_op_t   op,
  output wsd_pkg::ptr_stat_t stat,
  output logic [QW-1:0]      top_slot,
  output logic [QW-1:0]      bot_slot,
  output logic [QW-1:0]      pop_slot
);
  import wsd_pkg::*;

  localparam int unsigned PW = $clog2(2 * QUEUE_DEPTH);
  localparam logic [PW:0]   PMOD   = (PW + 1)'(2 * QUEUE_DEPTH);
  localparam logic [PW-1:0] PLAST  = PW'(2 * QUEUE_DEPTH - 1);
  localparam logic [PW-1:0] QD_P   = PW'(QUEUE_DEPTH);

  logic [PW-1:0] top [WORKERS];
  logic [PW-1:0] bottom [WORKERS];

  logic [PW-1:0] t;
  logic [PW-1:0] b;
  logic [PW-1:0] b_dec;
  logic [PW-1:0] b_inc;
  logic [PW-1:0] t_inc;
  logic [PW-1:0] count;
  logic [PW:0]   count_wrap;

  function automatic logic [QW-1:0] slot_of(input logic [PW-1:0] p);
    logic [PW-1:0] s;
    s = (p >= QD_P) ? (p - QD_P) : p;
    return s[QW-1:0];
  endfunction

  always_comb begin
    t          = top[sel];
    b          = bottom[sel];
    count_wrap = {1'b0, b} + PMOD - {1'b0, t};
    count      = (b >= t) ? (b - t) : count_wrap[PW-1:0];
    stat.empty = (count == '0);
    stat.full  = (count >= QD_P);
    b_dec      = (b == '0) ? PLAST : (b - PW'(1));
    b_inc      = (b == PLAST) ? '0 : (b + PW'(1));
    t_inc      = (t == PLAST) ? '0 : (t + PW'(1));
    top_slot   = slot_of(t);
    bot_slot   = slot_of(b);
    pop_slot   = slot_of(b_dec);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WORKERS; i++) begin
        top[i]    <= '0;
        bottom[i] <= '0;
      end
    end else begin
      if (op.push) begin
        bottom[sel] <= b_inc;
      end else if (op.pop) begin
        bottom[sel] <= b_dec;
      end
      if (op.steal) begin
        top[sel] <= t_inc;
      end
    end
  end

endmodule

[design/work_stealing_task_deques.sv]
// work-stealing scheduler top: request sequencer, victim scan, config register
//
//  channel | signals                                           | beat
//  --------+---------------------------------------------------+-----------------------
//  in      | in_valid in_ready opcode req_worker task_handle    | one push or fetch
//          | task_done                                         |
//  out     | out_valid out_ready out_task status was_stolen     | one result per request
//          | source_worker                                     |
//  cfg     | cfg_valid cfg_ready cfg_data                      | active_workers write
//
// a push runs S_CHECK, S_DONE; a fetch from the own deque runs S_CHECK, S_READ, S_DONE
// a steal or a miss adds S_SCAN, examining one worker at a time (shared occupancy check)
// after the own deque; a miss ends after min(active_workers, WORKERS) workers are scanned
// in_ready is high only while the sequencer is idle; a result waits in the output register
// synchronous reset empties every deque and sets active_workers to 1; no memory clearing
module work_stealing_task_deques #(
  parameter int unsigned WORKERS     = 8,
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       opcode,
  input  logic [wsd_pkg::WID_W-1:0]  req_worker,
  input  logic [wsd_pkg::TASK_W-1:0] task_handle,
  input  logic                       task_done,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [wsd_pkg::TASK_W-1:0] out_task,
  output logic [wsd_pkg::STAT_W-1:0] status,
  output logic                       was_stolen,
  output logic [wsd_pkg::WID_W-1:0]  source_worker,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wsd_pkg::CFG_W-1:0]  cfg_data
);
  import wsd_pkg::*;

  localparam int unsigned WW    = $clog2(WORKERS);
  localparam int unsigned SW    = $clog2(WORKERS + 1);
  localparam int unsigned QW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned DEPTH = WORKERS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam logic [AW-1:0] QD_A = AW'(QUEUE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_CHECK, S_SCAN, S_READ, S_DONE} state_t;

  state_t state;

  logic              op_q;
  logic [WID_W-1:0]  wid_q;
  logic [TASK_W-1:0] handle_q;
  logic              done_q;
  logic              own_ok;
  logic [SW-1:0]     scan_idx;
  logic [CFG_W-1:0]  active_workers;

  logic [TASK_W-1:0] res_task;
  logic [STAT_W-1:0] res_status;
  logic              res_stolen;
  logic [WID_W-1:0]  res_src;

  logic [WW-1:0]     sel;
  ptr_op_t           ptr_op;
  ptr_stat_t         ptr_stat;
  logic [QW-1:0]     top_slot;
  logic [QW-1:0]     bot_slot;
  logic [QW-1:0]     pop_slot;
  logic [QW-1:0]     mem_slot;
  logic [AW-1:0]     mem_addr;
  logic              mem_we;
  logic              mem_re;
  logic [TASK_W-1:0] mem_rdata;

  logic [SW-1:0]     lim;
  logic              scan_in_range;
  logic              scan_hit;
  logic              push_ok;
  logic              pop_ok;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    lim = (32'(active_workers) > 32'(WORKERS)) ? SW'(WORKERS) : SW'(active_workers);
    scan_in_range = (scan_idx < lim);
    sel = (state == S_SCAN) ? scan_idx[WW-1:0] : WW'(wid_q);
    scan_hit = (state == S_SCAN) && scan_in_range &&
               (32'(scan_idx) != 32'(wid_q)) && !ptr_stat.empty;
    push_ok = !done_q && own_ok && !ptr_stat.full;
    pop_ok  = own_ok && !ptr_stat.empty;

    ptr_op   = '0;
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_slot = bot_slot;
    case (state)
      S_CHECK: begin
        if (op_q == OP_PUSH) begin
          if (push_ok) begin
            ptr_op.push = 1'b1;
            mem_we      = 1'b1;
          end
        end else if (pop_ok) begin
          ptr_op.pop = 1'b1;
          mem_re     = 1'b1;
          mem_slot   = pop_slot;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          ptr_op.steal = 1'b1;
          mem_re       = 1'b1;
          mem_slot     = top_slot;
        end
      end
      default: begin
      end
    endcase
    mem_addr = AW'(sel) * QD_A + AW'(mem_slot);
  end

  wsd_ptr_file #(
    .WORKERS     (WORKERS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .WW          (WW),
    .QW          (QW)
  ) u_ptrs (
    .clk      (clk),
    .rst      (rst),
    .sel      (sel),
    .op       (ptr_op),
    .stat     (ptr_stat),
    .top_slot (top_slot),
    .bot_slot (bot_slot),
    .pop_slot (pop_slot)
  );

  wsd_task_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (handle_q),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      active_workers <= CFG_W'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_workers <= cfg_data;
      end
      // in S_DONE the result load below owns out_valid
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_q     <= opcode;
            wid_q    <= req_worker;
            handle_q <= task_handle;
            done_q   <= task_done;
            own_ok   <= (32'(req_worker) < 32'(WORKERS));
            state    <= S_CHECK;
          end
        end
        S_CHECK: begin
          res_task   <= '0;
          res_stolen <= 1'b0;
          res_src    <= '0;
          if (op_q == OP_PUSH) begin
            if (done_q) begin
              res_status <= ST_SKIP;
            end else if (push_ok) begin
              res_status <= ST_OK;
            end else begin
              res_status <= ST_FULL;
            end
            state <= S_DONE;
          end else if (pop_ok) begin
            res_status <= ST_OK;
            res_src    <= wid_q;
            state      <= S_READ;
          end else begin
            scan_idx <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!scan_in_range) begin
            res_status <= ST_NONE;
            state      <= S_DONE;
          end else if (scan_hit) begin
            res_status <= ST_OK;
            res_stolen <= 1'b1;
            res_src    <= WID_W'(scan_idx);
            state      <= S_READ;
          end else begin
            scan_idx <= scan_idx + SW'(1);
          end
        end
        S_READ: begin
          // read data from the previous cycle's access
          res_task <= mem_rdata;
          state    <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_task      <= res_task;
            status        <= res_status;
            was_stolen    <= res_stolen;
            source_worker <= res_src;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[tb/tb_work_stealing_task_deques.sv]
// self-checking testbench for the work-stealing task deques: directed table, then random phases
module tb_work_stealing_task_deques;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  localparam int WORKERS = 8;
  localparam int DEPTH   = 1024;
  localparam int LIMIT   = 400000;
  localparam int HOLD_AT = 200;
  localparam int HOLD_LEN = 400;

  typedef struct packed {
    logic [TASK_W-1:0] task_h;
    logic [STAT_W-1:0] st;
    logic              stolen;
    logic [WID_W-1:0]  src;
  } outcome_t;

  typedef struct packed {
    logic              has_cfg;
    logic [CFG_W-1:0]  cfg;
    logic              op;
    logic [WID_W-1:0]  wid;
    logic [TASK_W-1:0] h;
    logic              dn;
    logic              typed;
    outcome_t          want;
  } step_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              opcode = OP_PUSH;
  logic [WID_W-1:0]  req_worker = '0;
  logic [TASK_W-1:0] task_handle = '0;
  logic              task_done = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [TASK_W-1:0] out_task;
  logic [STAT_W-1:0] status;
  logic              was_stolen;
  logic [WID_W-1:0]  source_worker;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFG_W-1:0]  cfg_data = '0;

  // shadow copy of the deques and the steal range
  logic [TASK_W-1:0] deq_mem [WORKERS][DEPTH];
  logic [10:0]       deq_top [WORKERS];
  logic [10:0]       deq_bot [WORKERS];
  logic [CFG_W-1:0]  steal_span;

  outcome_t pending_outcomes [$];
  int       fail_count   = 0;
  int       results_seen = 0;
  int       cycles       = 0;
  bit       calm         = 1'b0;

  // directed table: typed outcomes where they follow at a glance
  step_row_t plan [28] = '{
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd7, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd0, 16'hFFFF, 1'b1, 1'b1, '{16'h0000, ST_SKIP, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd0, 16'hFFFF, 1'b0, 1'b1, '{16'h0000, ST_OK,   1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_OK,   1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd0, 16'h1234, 1'b0, 1'b1, '{16'h0000, ST_OK,   1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h1234, ST_OK,   1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd5, 16'h0000, 1'b0, 1'b1, '{16'hFFFF, ST_OK,   1'b1, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_OK,   1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd7, 16'hABCD, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd7, 16'h5A5A, 1'b1, 1'b1, '{16'h0000, ST_SKIP, 1'b0, 3'd0}},
    '{1'b1, 4'd8,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'hABCD, ST_OK,   1'b1, 3'd7}},
    '{1'b0, 4'd0,  OP_PUSH,  3'd3, 16'h5555, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_PUSH,  3'd6, 16'h6666, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_PUSH,  3'd1, 16'h1111, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd3, 16'h0000, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd3, 16'hAAAA, 1'b1, 1'b0, '0},
    '{1'b1, 4'd0,  OP_PUSH,  3'd2, 16'h2222, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd4, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd2, 16'h0000, 1'b0, 1'b1, '{16'h2222, ST_OK,   1'b0, 3'd2}},
    '{1'b1, 4'd15, OP_PUSH,  3'd7, 16'h7777, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h7777, ST_OK,   1'b1, 3'd7}},
    '{1'b1, 4'd7,  OP_PUSH,  3'd7, 16'h8888, 1'b0, 1'b0, '0},
    '{1'b0, 4'd0,  OP_FETCH, 3'd0, 16'h0000, 1'b0, 1'b1, '{16'h0000, ST_NONE, 1'b0, 3'd0}},
    '{1'b0, 4'd0,  OP_FETCH, 3'd7, 16'h0000, 1'b0, 1'b1, '{16'h8888, ST_OK,   1'b0, 3'd7}}
  };

  work_stealing_task_deques #(
    .WORKERS(WORKERS),
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .req_worker(req_worker),
    .task_handle(task_handle),
    .task_done(task_done),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_task(out_task),
    .status(status),
    .was_stolen(was_stolen),
    .source_worker(source_worker),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin : watchdog
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic logic [10:0] deq_fill(int w);
    return deq_bot[w] - deq_top[w];
  endfunction

  // next outcome of one request; updates the shadow deques
  function automatic outcome_t deque_outcome(logic op, logic [WID_W-1:0] wid,
                                             logic [TASK_W-1:0] h, logic dn);
    outcome_t r;
    int       lim;
    bit       found;
    r = '0;
    r.st = ST_NONE;
    found = 1'b0;
    if (op == OP_PUSH) begin
      // done wins over full
      if (dn) begin
        r.st = ST_SKIP;
      end else if (deq_fill(wid) >= DEPTH) begin
        r.st = ST_FULL;
      end else begin
        deq_mem[wid][deq_bot[wid][9:0]] = h;
        deq_bot[wid] = deq_bot[wid] + 11'd1;
        r.st = ST_OK;
      end
    end else if (deq_fill(wid) != 0) begin
      deq_bot[wid] = deq_bot[wid] - 11'd1;
      r.task_h = deq_mem[wid][deq_bot[wid][9:0]];
      r.st = ST_OK;
      r.src = wid;
    end else begin
      lim = (steal_span > WORKERS) ? WORKERS : int'(steal_span);
      for (int i = 0; i < lim; i++) begin
        if (!found && i != wid && deq_fill(i) != 0) begin
          r.task_h = deq_mem[i][deq_top[i][9:0]];
          deq_top[i] = deq_top[i] + 11'd1;
          r.st = ST_OK;
          r.stolen = 1'b1;
          r.src = 3'(i);
          found = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic send_item(logic op, logic [WID_W-1:0] wid, logic [TASK_W-1:0] h,
                           logic dn, logic typed, outcome_t want);
    outcome_t got;
    if (!calm && $urandom_range(99) < 38) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    opcode      <= op;
    req_worker  <= wid;
    task_handle <= h;
    task_done   <= dn;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    got = deque_outcome(op, wid, h, dn);
    pending_outcomes.push_back(typed ? want : got);
  endtask

  // write active_workers once every outstanding result is back
  task automatic set_span(logic [CFG_W-1:0] v);
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    steal_span = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic mixed_phase(logic [CFG_W-1:0] span, int n);
    set_span(span);
    repeat (n) begin
      send_item(($urandom_range(99) < 55) ? OP_PUSH : OP_FETCH, 3'($urandom_range(7)),
                16'($urandom), $urandom_range(99) < 12, 1'b0, '0);
    end
  endtask

  initial begin : stimulus
    for (int w = 0; w < WORKERS; w++) begin
      deq_top[w] = '0;
      deq_bot[w] = '0;
    end
    steal_span = 4'd1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].has_cfg) set_span(plan[k].cfg);
      send_item(plan[k].op, plan[k].wid, plan[k].h, plan[k].dn, plan[k].typed, plan[k].want);
    end

    // fill worker 3 to capacity, then hit it while full
    set_span(4'd8);
    while (deq_fill(3) < DEPTH) begin
      send_item(OP_PUSH, 3'd3, 16'($urandom), $urandom_range(19) == 0, 1'b0, '0);
    end
    repeat (6) send_item(OP_PUSH, 3'd3, 16'($urandom), 1'($urandom_range(1)), 1'b0, '0);
    // steal from the top, then refill so bottom wraps past the slot range
    repeat (160) begin
      send_item(OP_FETCH, 3'($urandom_range(4, 7)), 16'($urandom), 1'($urandom_range(1)),
                1'b0, '0);
    end
    calm = 1'b1;
    repeat (200) send_item(OP_PUSH, 3'd3, 16'($urandom), 1'b0, 1'b0, '0);
    calm = 1'b0;
    repeat (100) begin
      send_item(1'($urandom_range(1)), 3'd3, 16'($urandom), $urandom_range(9) == 0, 1'b0, '0);
    end

    mixed_phase(4'd1, 60);
    mixed_phase(4'd4, 60);
    mixed_phase(4'd0, 60);
    mixed_phase(4'd12, 60);
    mixed_phase(4'd8, 60);
    mixed_phase(4'($urandom_range(15)), 60);

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls, one long hold-off so the block backs up
  initial begin : drive_ready
    bit held;
    held = 1'b0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if (!held && results_seen >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_LEN) @(posedge clk);
      end
      out_ready <= calm || ($urandom_range(99) >= 38);
    end
  end

  always @(posedge clk) begin : check_results
    outcome_t want;
    outcome_t got;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      got = '{out_task, status, was_stolen, source_worker};
      if (pending_outcomes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result beat: task %h status %0d stolen %0d src %0d",
                   out_task, status, was_stolen, source_worker);
        end
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: exp %h/%0d/%0d/%0d got %h/%0d/%0d/%0d",
                     want.task_h, want.st, want.stolen, want.src,
                     out_task, status, was_stolen, source_worker);
          end
        end
      end
    end
  end

endmodule

[files.f]
design/wsd_pkg.sv
design/wsd_task_mem.sv
design/wsd_ptr_file.sv
design/work_stealing_task_deques.sv
tb/tb_work_stealing_task_deques.sv
